// ===== design/tqt_pkg.sv =====
// Package for the timer queue table: sizes, slot entry layout, status codes and
// the control and result records passed between the sequencer and the scan unit.
// Depends on nothing; every other file of the block imports it.
package tqt_pkg;

	localparam int SLOTS      = 16;
	localparam int TIME_BITS  = 32;
	localparam int ID_BITS    = 32;
	localparam int FIELD_BITS = 32;

	localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_BITS = ((TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS) + 1;
	localparam int CMP_BITS = (ID_BITS > FIELD_BITS) ? ID_BITS : FIELD_BITS;

	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [FIELD_BITS-1:0] field_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [SUM_BITS-1:0]   sum_t;
	typedef logic [CMP_BITS-1:0]   cmp_t;

	localparam time_t  TIME_MAX  = '1;
	localparam field_t FIELD_MAX = '1;

	// Operation codes; any other code is a tick.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FULL      = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPIRED   = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	typedef struct packed {
		time_t  expiry;
		field_t period;
		id_t    id;
	} slot_ent_t;

	typedef struct packed {
		logic   start;
		time_t  now;
		field_t cid;
	} scan_ctl_t;

	typedef struct packed {
		logic      done;
		logic      min_any;
		time_t     min_exp;
		logic      pick_found;
		idx_t      pick_idx;
		slot_ent_t pick_ent;
		logic      match_found;
		idx_t      match_idx;
	} scan_res_t;

	function automatic time_t sat_add(time_t a, field_t b);
		sum_t s;
		s = sum_t'(a) + sum_t'(b);
		if (s > sum_t'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return s[TIME_BITS-1:0];
	endfunction

	function automatic field_t clip_time(time_t v);
		if (sum_t'(v) > sum_t'(FIELD_MAX)) begin
			return FIELD_MAX;
		end
		return field_t'(v);
	endfunction

	function automatic field_t clip_id(id_t v);
		if (cmp_t'(v) > cmp_t'(FIELD_MAX)) begin
			return FIELD_MAX;
		end
		return field_t'(v);
	endfunction

endpackage

// ===== design/timer_queue_table_unit.sv =====
// Top level of the timer queue table: sequencer, slot valid bits, time and id
// counters, and the output register. Uses tqt_pkg, tqt_slot_ram and tqt_scan.
//
// The block holds up to 16 timers in a slot memory and handles one item at a
// time. Every item is served by passes over that memory, one slot read per
// cycle through its single read port. An add needs one pass, a cancel one
// or two, and a tick one pass per expired timer plus one more; each result
// also waits for the output side to take the one before it.
// The item after the last result is accepted while that result is still held.
// There is no clearing pass after reset: only the slot valid bits are cleared.
module timer_queue_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	input  logic [31:0] cancel_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] tmr_id,
	output logic        last,
	output logic        queue_empty,
	output logic [31:0] next_wait
);
	import tqt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_POST,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] fired_q;
	time_t            now_q;
	id_t              id_q;
	field_t           cid_q;
	logic             is_tick_q;
	logic             final_q;
	logic             have_pend_q;
	id_t              pend_id_q;
	status_t          res_status_q;
	id_t              res_id_q;
	logic             scan_start_q;

	logic    out_valid_q;
	status_t status_q;
	field_t  tmr_id_q;
	logic    last_q;
	logic    queue_empty_q;
	field_t  next_wait_q;

	logic      accept;
	logic      full;
	idx_t      free_idx;
	id_t       nxt_id;
	logic      out_free;
	logic      tick_step;
	logic      out_load;
	logic      scan_go;
	field_t    wait_val;
	logic      wr_en;
	idx_t      wr_idx;
	slot_ent_t wr_ent;
	logic      rd_en;
	idx_t      rd_idx;
	slot_ent_t rd_ent;
	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = &valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = idx_t'(i);
			end
		end
		nxt_id = id_q + id_t'(1);
		if (nxt_id == '0) begin
			nxt_id = id_t'(1);
		end
	end

	assign tick_step = (state_q == S_POST) && is_tick_q && scan_res.pick_found &&
		(!have_pend_q || out_free);

	assign out_load = (tick_step && have_pend_q) || ((state_q == S_EMIT) && out_free);

	assign scan_go = ((state_q == S_IDLE) && accept) || tick_step ||
		((state_q == S_POST) && !is_tick_q && !final_q && scan_res.match_found);

	always_comb begin
		if (state_q == S_IDLE) begin
			wr_en         = accept && (op == OP_ADD) && !full;
			wr_idx        = free_idx;
			wr_ent.expiry = sat_add(now_q, delay);
			wr_ent.period = period;
			wr_ent.id     = nxt_id;
		end else begin
			wr_en         = tick_step && (scan_res.pick_ent.period != '0);
			wr_idx        = scan_res.pick_idx;
			wr_ent.expiry = sat_add(now_q, scan_res.pick_ent.period);
			wr_ent.period = scan_res.pick_ent.period;
			wr_ent.id     = scan_res.pick_ent.id;
		end
	end

	always_comb begin
		if (scan_res.min_any && (scan_res.min_exp > now_q)) begin
			wait_val = clip_time(scan_res.min_exp - now_q);
		end else begin
			wait_val = '0;
		end
	end

	assign scan_ctl.start = scan_start_q;
	assign scan_ctl.now   = now_q;
	assign scan_ctl.cid   = cid_q;

	tqt_slot_ram u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_ent (wr_ent),
		.rd_en  (rd_en),
		.rd_idx (rd_idx),
		.rd_ent (rd_ent)
	);

	tqt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.valid_mask (valid_q),
		.fired_mask (fired_q),
		.rd_en      (rd_en),
		.rd_idx     (rd_idx),
		.rd_ent     (rd_ent),
		.res        (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			fired_q       <= '0;
			now_q         <= '0;
			id_q          <= '0;
			cid_q         <= '0;
			is_tick_q     <= 1'b0;
			final_q       <= 1'b0;
			have_pend_q   <= 1'b0;
			pend_id_q     <= '0;
			res_status_q  <= ST_NONE;
			res_id_q      <= '0;
			scan_start_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_NONE;
			tmr_id_q      <= '0;
			last_q        <= 1'b0;
			queue_empty_q <= 1'b0;
			next_wait_q   <= '0;
		end else begin
			scan_start_q <= scan_go;
			out_valid_q  <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WAIT;
						priority if (op == OP_ADD) begin
							is_tick_q <= 1'b0;
							final_q   <= 1'b1;
							if (full) begin
								res_status_q <= ST_FULL;
								res_id_q     <= '0;
							end else begin
								valid_q[free_idx] <= 1'b1;
								id_q              <= nxt_id;
								res_status_q      <= ST_ADDED;
								res_id_q          <= nxt_id;
							end
						end else if (op == OP_CANCEL) begin
							is_tick_q <= 1'b0;
							final_q   <= 1'b0;
							cid_q     <= cancel_id;
						end else begin
							is_tick_q   <= 1'b1;
							final_q     <= 1'b0;
							now_q       <= sat_add(now_q, field_t'(1));
							fired_q     <= '0;
							have_pend_q <= 1'b0;
						end
					end
				end
				S_WAIT: begin
					if (scan_res.done) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					priority if (is_tick_q) begin
						if (scan_res.pick_found) begin
							if (tick_step) begin
								if (have_pend_q) begin
									status_q      <= ST_EXPIRED;
									tmr_id_q      <= clip_id(pend_id_q);
									last_q        <= 1'b0;
									queue_empty_q <= 1'b0;
									next_wait_q   <= '0;
								end
								fired_q[scan_res.pick_idx] <= 1'b1;
								if (scan_res.pick_ent.period == '0) begin
									valid_q[scan_res.pick_idx] <= 1'b0;
								end
								pend_id_q   <= scan_res.pick_ent.id;
								have_pend_q <= 1'b1;
								state_q     <= S_WAIT;
							end
						end else begin
							res_status_q <= have_pend_q ? ST_EXPIRED : ST_NONE;
							res_id_q     <= have_pend_q ? pend_id_q : '0;
							state_q      <= S_EMIT;
						end
					end else if (final_q) begin
						state_q <= S_EMIT;
					end else if (scan_res.match_found) begin
						valid_q[scan_res.match_idx] <= 1'b0;
						res_status_q <= ST_CANCELLED;
						res_id_q     <= id_t'(cid_q);
						final_q      <= 1'b1;
						state_q      <= S_WAIT;
					end else begin
						res_status_q <= ST_NOT_FOUND;
						res_id_q     <= '0;
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						status_q      <= res_status_q;
						tmr_id_q      <= clip_id(res_id_q);
						last_q        <= 1'b1;
						queue_empty_q <= !scan_res.min_any;
						next_wait_q   <= wait_val;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign tmr_id      = tmr_id_q;
	assign last        = last_q;
	assign queue_empty = queue_empty_q;
	assign next_wait   = next_wait_q;

endmodule

// ===== design/tqt_slot_ram.sv =====
// Slot memory of the timer queue table: expiry, period and id of every slot.
// One write port and one read port with registered read data; uses tqt_pkg.
module tqt_slot_ram (
	input  logic             clk,
	input  logic             wr_en,
	input  tqt_pkg::idx_t     wr_idx,
	input  tqt_pkg::slot_ent_t wr_ent,
	input  logic             rd_en,
	input  tqt_pkg::idx_t     rd_idx,
	output tqt_pkg::slot_ent_t rd_ent
);
	import tqt_pkg::*;

	slot_ent_t mem_q [SLOTS];
	slot_ent_t rd_ent_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_ent;
		end
		if (rd_en) begin
			rd_ent_q <= mem_q[rd_idx];
		end
	end

	assign rd_ent = rd_ent_q;

endmodule

// ===== design/tqt_scan.sv =====
// Scan unit of the timer queue table: walks the slot memory one entry a cycle and
// gathers the earliest expiry, the next due timer and the first id match.
// Uses tqt_pkg and drives the read port of tqt_slot_ram.
module tqt_scan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tqt_pkg::scan_ctl_t        ctl,
	input  logic [tqt_pkg::SLOTS-1:0] valid_mask,
	input  logic [tqt_pkg::SLOTS-1:0] fired_mask,
	output logic                     rd_en,
	output tqt_pkg::idx_t             rd_idx,
	input  tqt_pkg::slot_ent_t        rd_ent,
	output tqt_pkg::scan_res_t        res
);
	import tqt_pkg::*;

	logic      run_q;
	idx_t      cnt_q;
	logic      rd_v_s1;
	idx_t      idx_s1;
	logic      done_q;
	logic      min_any_q;
	time_t     min_exp_q;
	logic      pick_found_q;
	idx_t      pick_idx_q;
	slot_ent_t pick_ent_q;
	logic      match_found_q;
	idx_t      match_idx_q;

	logic ent_ok;
	logic is_due;
	logic better_pick;
	logic better_min;
	logic is_match;

	assign rd_en  = run_q;
	assign rd_idx = cnt_q;

	always_comb begin
		ent_ok      = rd_v_s1 && valid_mask[idx_s1];
		is_due      = ent_ok && !fired_mask[idx_s1] && (rd_ent.expiry <= ctl.now);
		better_pick = !pick_found_q || (rd_ent.expiry < pick_ent_q.expiry) ||
			((rd_ent.expiry == pick_ent_q.expiry) && (rd_ent.id < pick_ent_q.id));
		better_min  = !min_any_q || (rd_ent.expiry < min_exp_q);
		is_match    = ent_ok && (ctl.cid != '0) && (cmp_t'(rd_ent.id) == cmp_t'(ctl.cid));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= 1'b0;
			cnt_q         <= '0;
			rd_v_s1       <= 1'b0;
			idx_s1        <= '0;
			done_q        <= 1'b0;
			min_any_q     <= 1'b0;
			min_exp_q     <= '0;
			pick_found_q  <= 1'b0;
			pick_idx_q    <= '0;
			pick_ent_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
		end else begin
			rd_v_s1 <= run_q;
			idx_s1  <= cnt_q;
			done_q  <= rd_v_s1 && (idx_s1 == idx_t'(SLOTS - 1));
			if (ctl.start) begin
				run_q         <= 1'b1;
				cnt_q         <= '0;
				min_any_q     <= 1'b0;
				pick_found_q  <= 1'b0;
				match_found_q <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q + idx_t'(1);
				if (cnt_q == idx_t'(SLOTS - 1)) begin
					run_q <= 1'b0;
				end
			end
			if (ent_ok && better_min) begin
				min_any_q <= 1'b1;
				min_exp_q <= rd_ent.expiry;
			end
			if (is_due && better_pick) begin
				pick_found_q <= 1'b1;
				pick_idx_q   <= idx_s1;
				pick_ent_q   <= rd_ent;
			end
			if (is_match && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
			end
		end
	end

	always_comb begin
		res.done        = done_q;
		res.min_any     = min_any_q;
		res.min_exp     = min_exp_q;
		res.pick_found  = pick_found_q;
		res.pick_idx    = pick_idx_q;
		res.pick_ent    = pick_ent_q;
		res.match_found = match_found_q;
		res.match_idx   = match_idx_q;
	end

endmodule

// ===== design/tqt_checker.sv =====
// Port checker for the timer queue table, attached to the top level by bind.
// Uses tqt_pkg for the status codes.
module tqt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] tmr_id,
	input logic        last,
	input logic        queue_empty,
	input logic [31:0] next_wait
);
	import tqt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(tmr_id) &&
			$stable(last))
		else $error("Result changed while stalled.");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_EXPIRED && !queue_empty && next_wait == '0)
		else $error("A result that is not the last of its item is malformed.");

	a_empty_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |-> next_wait == '0)
		else $error("Empty table reported with a nonzero wait.");

	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_NOT_FOUND || status == ST_NONE)
			|-> tmr_id == '0 && last)
		else $error("Status without a timer carries an id or is not last.");

	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> tmr_id != '0 && !queue_empty && last)
		else $error("Added timer reported without an id or with an empty table.");

endmodule

bind timer_queue_table_unit tqt_checker u_tqt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.tmr_id      (tmr_id),
	.last        (last),
	.queue_empty (queue_empty),
	.next_wait   (next_wait)
);
